>>> rtl/core/arwe_pkg.sv
// Shared types and constants for the ack rate and window estimator.
package arwe_pkg;

  // Field widths
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned TPUT_W   = 26;
  localparam int unsigned WIN_W    = 26;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 56;

  // Shared divider geometry
  localparam int unsigned DVD_W  = 46;
  localparam int unsigned DIVR_W = 32;
  localparam int unsigned CNT_W  = 6;

  // Multiplier geometry
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic REG_UPDATE_INTERVAL = 1'b0;
  localparam logic REG_RTT_ESTIMATE    = 1'b1;

  // Reset values and Q16 coefficients
  localparam logic [CFG_W-1:0]  INTERVAL_RESET = 16'd20;
  localparam logic [CFG_W-1:0]  RTT_EST_RESET  = 16'd60;
  localparam logic [TPUT_W-1:0] TPUT_RESET     = 26'd6554;
  localparam logic [TPUT_W-1:0] TPUT_MAX       = 26'h3FF_FFFF;
  localparam logic [MUL_B_W-1:0] DECAY_Q16     = 16'd51773;
  localparam logic [MUL_B_W-1:0] GAIN_Q16      = 16'd22938;

  // 1.0 in Q16, aligned to the top of the dividend for a 17-step division
  localparam int unsigned        INV_STEPS   = 17;
  localparam logic [DVD_W-1:0]   INV_DVD     = 46'd1 << (DVD_W - 1);
  localparam logic [CNT_W-1:0]   INV_STEPS_C = CNT_W'(INV_STEPS);
  localparam logic [CNT_W-1:0]   GAIN_STEPS_C = CNT_W'(DVD_W);

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

endpackage

>>> rtl/core/arwe_div.sv
// Shared restoring divider, one quotient bit per cycle.
module arwe_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  arwe_pkg::div_req_t           req_i,
  input  logic [arwe_pkg::DVD_W-1:0]   dividend_i,
  input  logic [arwe_pkg::DIVR_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [arwe_pkg::DVD_W-1:0]   quotient_o
);

  logic [arwe_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [arwe_pkg::DIVR_W-1:0] rem_q, rem_d;
  logic [arwe_pkg::DIVR_W-1:0] divr_q, divr_d;
  logic [arwe_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [arwe_pkg::DIVR_W:0]   shifted;
  logic [arwe_pkg::DIVR_W:0]   trial;

  assign shifted = {rem_q, dvd_q[arwe_pkg::DVD_W-1]};
  assign trial   = shifted - {1'b0, divr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    divr_d = divr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      divr_d = divisor_i;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restore when the trial subtraction goes negative
      if (trial[arwe_pkg::DIVR_W]) begin
        rem_d = shifted[arwe_pkg::DIVR_W-1:0];
        dvd_d = {dvd_q[arwe_pkg::DVD_W-2:0], 1'b0};
      end else begin
        rem_d = trial[arwe_pkg::DIVR_W-1:0];
        dvd_d = {dvd_q[arwe_pkg::DVD_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == arwe_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    divr_q <= divr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

>>> rtl/core/ack_rate_window_estimator.sv
// Top level: throughput estimate and congestion window per acknowledgement.
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready | seq_acked, send_time, ack_time
//  m_axis    | out | m_axis_tvalid/m_axis_tready | window_packets, rate_estimate
//  cfg       | in  | cfg_we_i (always taken)     | cfg_idx_i, cfg_data_i
//
// An ack that triggers an update uses one serial divider twice: 17 steps for 1/rtt,
// then 46 steps for the gain quotient. An ack that does not update goes straight
// from the check to the window step. The block takes one ack at a time.
// A finished result sits in the output register, so the next ack is taken
// while it waits; a new result stalls only if the previous one is still held.
module ack_rate_window_estimator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] seq_acked, [63:32] send_time, [95:64] ack_time
  input  logic [arwe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [25:0] window_packets, [51:26] rate_estimate, [55:52] zero
  output logic [arwe_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [arwe_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_INV   = 3'd2;
  localparam logic [2:0] S_GAIN  = 3'd3;
  localparam logic [2:0] S_BLEND = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;
  localparam logic [2:0] S_WIN   = 3'd6;

  logic [2:0] state_q, state_d;

  logic [arwe_pkg::CFG_W-1:0]  interval_q, rtt_est_q;
  logic [arwe_pkg::TPUT_W-1:0] tput_q, tput_d;
  logic [arwe_pkg::TIME_W-1:0] last_time_q, last_time_d;
  logic [arwe_pkg::SEQ_W-1:0]  last_seq_q, last_seq_d;

  logic [arwe_pkg::SEQ_W-1:0]  seq_q;
  logic [arwe_pkg::TIME_W-1:0] send_q, ack_q;

  logic                        neg_q;
  logic [arwe_pkg::DVD_W-1:0]  gain_prod_q;
  logic [arwe_pkg::TPUT_W-1:0] decay_q, inv_q, blend_q;
  logic [arwe_pkg::DVD_W-1:0]  gain_q;

  logic                         out_vld_q;
  logic [arwe_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                         s_xfer, out_load;
  logic [arwe_pkg::TIME_W-1:0]  elapsed, rtt_full;
  logic [arwe_pkg::TIME_W-2:0]  rtt;
  logic [arwe_pkg::SEQ_W-1:0]   delta, delta_mag;
  logic                         do_update;

  logic [arwe_pkg::MUL_A_W-1:0] mul_a;
  logic [arwe_pkg::MUL_B_W-1:0] mul_b;
  logic [arwe_pkg::MUL_P_W-1:0] mul_p;

  arwe_pkg::div_req_t           div_req;
  logic [arwe_pkg::DVD_W-1:0]   div_dvd;
  logic [arwe_pkg::DIVR_W-1:0]  div_divr;
  logic                         div_done;
  logic [arwe_pkg::DVD_W-1:0]   div_quot;

  logic [arwe_pkg::DVD_W:0]     sum_pos;
  logic [arwe_pkg::TPUT_W-1:0]  blend_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign elapsed   = ack_q - last_time_q;
  assign rtt_full  = ack_q - send_q;
  assign rtt       = rtt_full[arwe_pkg::TIME_W-1:1];
  assign delta     = seq_q - last_seq_q;
  assign delta_mag = delta[arwe_pkg::SEQ_W-1] ? (~delta + 1'b1) : delta;
  assign do_update = (elapsed >= {16'd0, interval_q});

  // One shared multiplier; operands follow the sequencer step
  always_comb begin
    unique case (state_q)
      S_CHECK: begin
        mul_a = delta_mag;
        mul_b = arwe_pkg::GAIN_Q16;
      end
      S_INV: begin
        mul_a = {6'd0, tput_q};
        mul_b = arwe_pkg::DECAY_Q16;
      end
      default: begin
        mul_a = {6'd0, tput_q};
        mul_b = rtt_est_q;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Divider feed: 1/rtt first, then the gain quotient
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = arwe_pkg::INV_STEPS_C;
    div_dvd       = arwe_pkg::INV_DVD;
    div_divr      = {1'b0, rtt};
    if (state_q == S_CHECK && do_update) begin
      div_req.start = 1'b1;
    end else if (state_q == S_INV && div_done) begin
      div_req.start = 1'b1;
      div_req.steps = arwe_pkg::GAIN_STEPS_C;
      div_dvd       = gain_prod_q;
      div_divr      = (elapsed == '0) ? arwe_pkg::DIVR_W'(1) : elapsed;
    end
  end

  arwe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_divr),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Blend of decay and signed gain, clamped to the Q10.16 range
  assign sum_pos = {21'd0, decay_q} + {1'b0, gain_q};
  always_comb begin
    if (neg_q) begin
      if (gain_q > {20'd0, decay_q}) begin
        blend_d = '0;
      end else begin
        blend_d = decay_q - gain_q[arwe_pkg::TPUT_W-1:0];
      end
    end else if (sum_pos > {21'd0, arwe_pkg::TPUT_MAX}) begin
      blend_d = arwe_pkg::TPUT_MAX;
    end else begin
      blend_d = sum_pos[arwe_pkg::TPUT_W-1:0];
    end
  end

  assign out_load = (state_q == S_WIN) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    tput_d      = tput_q;
    last_time_d = last_time_q;
    last_seq_d  = last_seq_q;
    unique case (state_q)
      S_IDLE:  if (s_xfer) state_d = S_CHECK;
      S_CHECK: state_d = do_update ? S_INV : S_WIN;
      S_INV:   if (div_done) state_d = S_GAIN;
      S_GAIN:  if (div_done) state_d = S_BLEND;
      S_BLEND: state_d = S_APPLY;
      S_APPLY: begin
        tput_d      = (inv_q > blend_q) ? inv_q : blend_q;
        last_time_d = ack_q;
        last_seq_d  = seq_q;
        state_d     = S_WIN;
      end
      S_WIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      interval_q  <= arwe_pkg::INTERVAL_RESET;
      rtt_est_q   <= arwe_pkg::RTT_EST_RESET;
      tput_q      <= arwe_pkg::TPUT_RESET;
      last_time_q <= '0;
      last_seq_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tput_q      <= tput_d;
      last_time_q <= last_time_d;
      last_seq_q  <= last_seq_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          arwe_pkg::REG_UPDATE_INTERVAL: interval_q <= cfg_data_i;
          arwe_pkg::REG_RTT_ESTIMATE:    rtt_est_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      seq_q  <= s_axis_tdata[31:0];
      send_q <= s_axis_tdata[63:32];
      ack_q  <= s_axis_tdata[95:64];
    end
    if (state_q == S_CHECK) begin
      neg_q       <= delta[arwe_pkg::SEQ_W-1];
      gain_prod_q <= mul_p[arwe_pkg::DVD_W-1:0];
    end
    if (state_q == S_INV) begin
      decay_q <= mul_p[41:16];
      if (div_done) begin
        // a zero rtt counts as the largest reciprocal
        inv_q <= (rtt == '0) ? arwe_pkg::TPUT_MAX : {9'd0, div_quot[16:0]};
      end
    end
    if (state_q == S_GAIN && div_done) begin
      gain_q <= div_quot;
    end
    if (state_q == S_BLEND) begin
      blend_q <= blend_d;
    end
    if (out_load) begin
      out_data_q <= {4'd0, tput_q, mul_p[41:16]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/arwe_checker.sv
// Port-level checks for the estimator, bound to the top level.
module arwe_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [arwe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [arwe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            cfg_we_i,
  input logic                            cfg_idx_i,
  input logic [arwe_pkg::CFG_W-1:0]      cfg_data_i
);

  // The block works on one ack at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again straight after a transfer");

  // A fresh result is loaded on the step that frees the input side
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while the input side is still busy");

  // Window is rate times a factor below one
  a_window_below_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:0] <= m_axis_tdata[51:26]))
    else $error("window exceeds the rate estimate");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind ack_rate_window_estimator arwe_checker u_arwe_checker (.*);
